// ===== hw/rtl/polygon_arc_vertex_generator_assert.svh =====
// assertion macros for the polygon arc vertex generator
`ifndef POLYGON_ARC_VERTEX_GENERATOR_ASSERT_SVH
`define POLYGON_ARC_VERTEX_GENERATOR_ASSERT_SVH

// condition or implication checked at every rising clock edge outside reset
`define PAV_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define PAV_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/pav_pkg.sv =====
// shared types and constants of the polygon arc vertex generator
package pav_pkg;

  localparam logic [1:0] CMD_POLYGON = 2'd0;
  localparam logic [1:0] CMD_ELLIPSE = 2'd1;
  localparam logic [1:0] CMD_ARC     = 2'd2;

  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [33:0] CORDIC_INIT_X = 34'sh026DD3B6A;
  localparam int COORD_LIMIT = 65535;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CORDIC,
    ST_MUL,
    ST_OUT
  } pav_state_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [33:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    begin
      unique case (i)
        5'd0:  v = 32'h20000000;
        5'd1:  v = 32'h12E4051E;
        5'd2:  v = 32'h09FB385B;
        5'd3:  v = 32'h051111D4;
        5'd4:  v = 32'h028B0D43;
        5'd5:  v = 32'h0145D7E1;
        5'd6:  v = 32'h00A2F61E;
        5'd7:  v = 32'h00517C55;
        5'd8:  v = 32'h0028BE53;
        5'd9:  v = 32'h00145F2F;
        5'd10: v = 32'h000A2F98;
        5'd11: v = 32'h000517CC;
        5'd12: v = 32'h00028BE6;
        5'd13: v = 32'h000145F3;
        5'd14: v = 32'h0000A2FA;
        5'd15: v = 32'h0000517D;
        5'd16: v = 32'h000028BE;
        5'd17: v = 32'h0000145F;
        5'd18: v = 32'h00000A30;
        5'd19: v = 32'h00000518;
        5'd20: v = 32'h0000028C;
        5'd21: v = 32'h00000146;
        5'd22: v = 32'h000000A3;
        5'd23: v = 32'h00000051;
        default: v = 32'h0;
      endcase
      atan_turns = {2'b00, v};
    end
  endfunction

endpackage

// ===== hw/rtl/polygon_arc_vertex_generator.sv =====
// polygon, ellipse and arc vertex generator with a shared iterative cordic
//
// usage: one request transaction on the in_ channel (in_valid/in_stall)
// names a figure; the block then emits its vertices one at a time on the
// out_ channel (out_valid/out_stall), out_last marking the final vertex.
// a polygon or ellipse gives count vertices and an arc count+1, both
// capped at MAX_POINTS; a count below three or an unknown command gives
// nothing. the step division runs first (one quotient bit per cycle in
// a restoring divider); then each vertex takes a cordic setup, the
// micro-rotations, a multiply for x and then one for y on one shared
// 17x34 multiplier, and an output step.
// in_stall is high from acceptance until the last vertex has been taken.
// while out_stall is high the current vertex is held unchanged and work
// pauses. synchronous active-low reset returns the block to idle with no
// vertex pending.
module polygon_arc_vertex_generator
  import pav_pkg::*;
#(
  parameter int MAX_POINTS   = 64,
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [6:0]         in_count,
  input  logic [15:0]        in_radius_x,
  input  logic [15:0]        in_radius_y,
  input  logic [15:0]        in_start_angle,
  input  logic signed [17:0] in_span_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_x,
  output logic signed [16:0] out_y,
  output logic               out_last
);

  localparam int ITW = $clog2(CORDIC_STEPS);
  localparam int DIV_BITS = 34;
  localparam logic [ITW-1:0] LAST_IT = ITW'(CORDIC_STEPS - 1);
  localparam logic [31:0] ANG_MASK = 32'hFFFFFFFF << (32 - ANGLE_BITS);

  pav_state_t state_r, state_nxt;

  logic [31:0]        phase_r;
  logic signed [32:0] phase_step_r;
  logic [6:0]         points_left_r;
  logic [15:0]        held_radius_x_r, held_radius_y_r;
  logic               neg_r;
  // divider registers
  logic [33:0]        quo_r;
  logic [6:0]         rem_r;
  logic [6:0]         divisor_r;
  logic [5:0]         div_cnt_r;
  // cordic registers
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [ITW-1:0]     it_r;
  logic               flip_r;
  logic               ang_setup_done_r;
  logic               mul_sel_r;
  logic signed [16:0] x_r, y_r;
  logic               last_r;

  // request decode
  logic       req_ok;
  logic [6:0] n_sat;
  always_comb begin
    req_ok = ((in_command == CMD_POLYGON) || (in_command == CMD_ELLIPSE) ||
              (in_command == CMD_ARC)) && (in_count >= 7'd3);
    if (in_command == CMD_ARC)
      n_sat = (in_count > 7'(MAX_POINTS - 1)) ? 7'(MAX_POINTS - 1) : in_count;
    else
      n_sat = (in_count > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : in_count;
  end

  // restoring divider step, one quotient bit per cycle
  logic [7:0]  rem_sh;
  logic [7:0]  rem_sub;
  logic [33:0] quo_nxt;
  always_comb begin
    rem_sh  = {rem_r, quo_r[33]};
    rem_sub = rem_sh - {1'b0, divisor_r};
    quo_nxt = {quo_r[32:0], ~rem_sub[7]};
  end

  // cordic setup from phase
  logic [31:0]        ang_a;
  logic               ang_flip;
  always_comb begin
    ang_a    = phase_r & ANG_MASK;
    ang_flip = (ang_a >= 32'h40000000) && (ang_a < 32'hC0000000);
    if (ang_flip)
      ang_a = ang_a - 32'h80000000;
  end

  // shared multiplier and rounding
  logic signed [16:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [50:0] prod;
  logic signed [50:0] prod_sh;
  logic signed [16:0] coord;
  always_comb begin
    mul_a   = mul_sel_r ? $signed({1'b0, held_radius_y_r}) : $signed({1'b0, held_radius_x_r});
    mul_b   = mul_sel_r ? (flip_r ? -cy_r : cy_r) : (flip_r ? -cx_r : cx_r);
    prod    = 51'(mul_a) * 51'(mul_b) + 51'sd536870912;
    prod_sh = prod >>> 30;
    if (prod_sh > 51'sd65535)
      coord = 17'sd65535;
    else if (prod_sh < -51'sd65535)
      coord = -17'sd65535;
    else
      coord = prod_sh[16:0];
  end

  logic cordic_done;
  assign cordic_done = ang_setup_done_r && (it_r == LAST_IT);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= ST_IDLE;
    else
      state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid && req_ok) state_nxt = ST_DIV;
      ST_DIV:    if (div_cnt_r == 6'(DIV_BITS - 1)) state_nxt = ST_CORDIC;
      ST_CORDIC: if (cordic_done) state_nxt = ST_MUL;
      ST_MUL:    if (mul_sel_r) state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_stall)
          state_nxt = (points_left_r == 7'd1) ? ST_IDLE : ST_CORDIC;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= '0;
      phase_step_r    <= '0;
      points_left_r   <= '0;
      held_radius_x_r <= '0;
      held_radius_y_r <= '0;
      div_cnt_r       <= '0;
      it_r            <= '0;
      mul_sel_r       <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && req_ok) begin
            held_radius_x_r <= in_radius_x;
            held_radius_y_r <= (in_command == CMD_ELLIPSE) ? in_radius_y : in_radius_x;
            phase_r   <= (in_command == CMD_ELLIPSE) ? 32'h0 : {in_start_angle, 16'h0};
            divisor_r <= n_sat;
            rem_r     <= '0;
            div_cnt_r <= '0;
            if (in_command == CMD_ARC) begin
              points_left_r <= n_sat + 7'd1;
              neg_r <= in_span_angle[17];
              quo_r <= {(in_span_angle[17] ? 18'(-in_span_angle) : 18'(in_span_angle)),
                        16'h0};
            end else begin
              points_left_r <= n_sat;
              neg_r <= 1'b0;
              quo_r <= 34'h100000000;
            end
          end
        end
        ST_DIV: begin
          div_cnt_r <= div_cnt_r + 6'd1;
          if (!rem_sub[7]) begin
            rem_r <= rem_sub[6:0];
            quo_r <= {quo_r[32:0], 1'b1};
          end else begin
            rem_r <= rem_sh[6:0];
            quo_r <= {quo_r[32:0], 1'b0};
          end
          if (div_cnt_r == 6'(DIV_BITS - 1)) begin
            phase_step_r <= neg_r ? -$signed(quo_nxt[32:0]) : $signed(quo_nxt[32:0]);
            it_r <= '0;
          end
        end
        ST_CORDIC: begin
          if (it_r == '0 && !ang_setup_done_r) begin
            cx_r <= CORDIC_INIT_X;
            cy_r <= '0;
            cz_r <= {{2{ang_a[31]}}, ang_a};
            flip_r <= ang_flip;
          end else begin
            if (!cz_r[33]) begin
              cx_r <= cx_r - (cy_r >>> it_r);
              cy_r <= cy_r + (cx_r >>> it_r);
              cz_r <= cz_r - atan_turns(5'(it_r));
            end else begin
              cx_r <= cx_r + (cy_r >>> it_r);
              cy_r <= cy_r - (cx_r >>> it_r);
              cz_r <= cz_r + atan_turns(5'(it_r));
            end
            it_r <= it_r + ITW'(1);
          end
          mul_sel_r <= 1'b0;
        end
        ST_MUL: begin
          if (!mul_sel_r) x_r <= coord;
          else y_r <= coord;
          mul_sel_r <= ~mul_sel_r;
          last_r <= (points_left_r == 7'd1);
        end
        ST_OUT: begin
          if (!out_stall) begin
            points_left_r <= points_left_r - 7'd1;
            phase_r <= phase_r + phase_step_r[31:0];
            it_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // a setup step precedes the micro-rotations of each vertex
  always_ff @(posedge clk) begin
    if (!rst_n)
      ang_setup_done_r <= 1'b0;
    else if (state_r == ST_CORDIC)
      ang_setup_done_r <= 1'b1;
    else
      ang_setup_done_r <= 1'b0;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_last  = last_r;

  // handshake helpers for the checks below
  logic        out_take;
  logic [34:0] out_word;
  assign out_take = out_valid && !out_stall;
  assign out_word = {out_x, out_y, out_last};

  `include "polygon_arc_vertex_generator_assert.svh"

  `PAV_ASSERT(a_out_only_busy, !(out_valid && !in_stall), "output while idle")
  `PAV_ASSERT_NEXT(a_last_idle, out_take && out_last, !out_valid && !in_stall, "no idle after last")
  `PAV_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_word), "vertex changed")
  `PAV_ASSERT(a_left_nonzero, !(out_valid && points_left_r == 7'd0), "vertex with nothing left")

endmodule
